/* rtl/core/json_string_unescape_unit_assert.svh */
// Assertion macros for the JSON string unescape unit.
`ifndef JSON_STRING_UNESCAPE_UNIT_ASSERT_SVH
`define JSON_STRING_UNESCAPE_UNIT_ASSERT_SVH

// Check that the consequent holds in the same cycle as the antecedent.
`define JSU_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Check that the consequent holds in the cycle after the antecedent.
`define JSU_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/core/jsu_pkg.sv */
// Types, codes and helpers shared by the JSON string unescape unit.
`default_nettype none

package jsu_pkg;

    typedef enum logic [2:0] {
        MODE_AWAIT  = 3'd0,
        MODE_STRING = 3'd1,
        MODE_ESCAPE = 3'd2,
        MODE_HEX    = 3'd3,
        MODE_CLOSED = 3'd4,
        MODE_ERROR  = 3'd5
    } t_mode;

    typedef enum logic [2:0] {
        KIND_DATA       = 3'd0,
        KIND_CLOSED     = 3'd1,
        KIND_NO_OPEN    = 3'd2,
        KIND_UNFINISHED = 3'd3,
        KIND_BAD_ESC    = 3'd4,
        KIND_BAD_HEX    = 3'd5,
        KIND_SHORT_U    = 3'd6,
        KIND_UNTERM     = 3'd7
    } t_kind;

    localparam logic ACT_BYTE = 1'b0;
    localparam logic ACT_END  = 1'b1;

    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5c;
    localparam logic [7:0] CH_SLASH  = 8'h2f;
    localparam logic [7:0] CH_B      = 8'h62;
    localparam logic [7:0] CH_F      = 8'h66;
    localparam logic [7:0] CH_N      = 8'h6e;
    localparam logic [7:0] CH_R      = 8'h72;
    localparam logic [7:0] CH_T      = 8'h74;
    localparam logic [7:0] CH_U      = 8'h75;

    localparam logic [7:0] CTL_BS  = 8'h08;
    localparam logic [7:0] CTL_FF  = 8'h0c;
    localparam logic [7:0] CTL_LF  = 8'h0a;
    localparam logic [7:0] CTL_CR  = 8'h0d;
    localparam logic [7:0] CTL_TAB = 8'h09;

    localparam logic [1:0] HEX_LAST = 2'd3;

    typedef struct packed {
        logic       action;
        logic [7:0] text_byte;
    } t_in_item;

    typedef struct packed {
        t_kind      kind;
        logic [1:0] byte_count;
        logic [7:0] first_byte;
        logic [7:0] second_byte;
        logic [7:0] third_byte;
    } t_out_item;

    // Parser state; the code holds the first three hex digits of a \u escape.
    typedef struct packed {
        t_mode       mode;
        logic [1:0]  hex_cnt;
        logic [11:0] code;
    } t_state;

    typedef struct packed {
        logic      has_result;
        t_out_item item;
    } t_step;

    localparam t_state ST_RESET = '{mode: MODE_AWAIT, hex_cnt: 2'd0, code: 12'd0};

    typedef struct packed {
        logic       ok;
        logic [3:0] val;
    } t_hex;

    function automatic t_hex hex_value(input logic [7:0] c);
        t_hex h;
        h.ok  = 1'b1;
        h.val = 4'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            h.val = 4'(c - 8'h30);
        end else if (c >= 8'h61 && c <= 8'h66) begin
            h.val = 4'(c - 8'h57);
        end else if (c >= 8'h41 && c <= 8'h46) begin
            h.val = 4'(c - 8'h37);
        end else begin
            h.ok = 1'b0;
        end
        return h;
    endfunction

endpackage

`default_nettype wire

/* rtl/core/jsu_step.sv */
// Next-state and result logic for one item of the JSON string unescaper.
`default_nettype none

module jsu_step (
    input  jsu_pkg::t_in_item i_item,
    input  jsu_pkg::t_state   i_state,
    output jsu_pkg::t_state   o_state,
    output jsu_pkg::t_step    o_step
);
    import jsu_pkg::*;

    t_hex        hex;
    logic [15:0] cp;

    function automatic t_out_item utf8(input logic [15:0] c);
        t_out_item r;
        r = '{kind: KIND_DATA, byte_count: 2'd0,
              first_byte: 8'd0, second_byte: 8'd0, third_byte: 8'd0};
        if (c <= 16'h007f) begin
            r.byte_count = 2'd1;
            r.first_byte = {1'b0, c[6:0]};
        end else if (c <= 16'h07ff) begin
            r.byte_count  = 2'd2;
            r.first_byte  = {3'b110, c[10:6]};
            r.second_byte = {2'b10, c[5:0]};
        end else begin
            r.byte_count  = 2'd3;
            r.first_byte  = {4'b1110, c[15:12]};
            r.second_byte = {2'b10, c[11:6]};
            r.third_byte  = {2'b10, c[5:0]};
        end
        return r;
    endfunction

    assign hex = hex_value(i_item.text_byte);
    assign cp  = {i_state.code, hex.val};

    always_comb begin
        o_state           = i_state;
        o_step.has_result = 1'b0;
        o_step.item       = '{kind: KIND_DATA, byte_count: 2'd0,
                              first_byte: 8'd0, second_byte: 8'd0, third_byte: 8'd0};
        if (i_item.action == ACT_END) begin
            o_state = ST_RESET;
            case (i_state.mode)
                MODE_AWAIT: begin
                    o_step.has_result = 1'b1;
                    o_step.item.kind  = KIND_NO_OPEN;
                end
                MODE_STRING: begin
                    o_step.has_result = 1'b1;
                    o_step.item.kind  = KIND_UNTERM;
                end
                MODE_ESCAPE: begin
                    o_step.has_result = 1'b1;
                    o_step.item.kind  = KIND_UNFINISHED;
                end
                MODE_HEX: begin
                    o_step.has_result = 1'b1;
                    o_step.item.kind  = KIND_SHORT_U;
                end
                default: begin
                end
            endcase
        end else begin
            case (i_state.mode)
                MODE_AWAIT: begin
                    if (i_item.text_byte == CH_QUOTE) begin
                        o_state.mode = MODE_STRING;
                    end else begin
                        o_state           = '{mode: MODE_ERROR, hex_cnt: 2'd0, code: 12'd0};
                        o_step.has_result = 1'b1;
                        o_step.item.kind  = KIND_NO_OPEN;
                    end
                end
                MODE_STRING: begin
                    if (i_item.text_byte == CH_QUOTE) begin
                        o_state.mode      = MODE_CLOSED;
                        o_step.has_result = 1'b1;
                        o_step.item.kind  = KIND_CLOSED;
                    end else if (i_item.text_byte == CH_BSLASH) begin
                        o_state.mode = MODE_ESCAPE;
                    end else begin
                        o_step.has_result       = 1'b1;
                        o_step.item.byte_count  = 2'd1;
                        o_step.item.first_byte  = i_item.text_byte;
                    end
                end
                MODE_ESCAPE: begin
                    o_state.mode           = MODE_STRING;
                    o_step.has_result      = 1'b1;
                    o_step.item.byte_count = 2'd1;
                    case (i_item.text_byte)
                        CH_QUOTE:  o_step.item.first_byte = CH_QUOTE;
                        CH_BSLASH: o_step.item.first_byte = CH_BSLASH;
                        CH_SLASH:  o_step.item.first_byte = CH_SLASH;
                        CH_B:      o_step.item.first_byte = CTL_BS;
                        CH_F:      o_step.item.first_byte = CTL_FF;
                        CH_N:      o_step.item.first_byte = CTL_LF;
                        CH_R:      o_step.item.first_byte = CTL_CR;
                        CH_T:      o_step.item.first_byte = CTL_TAB;
                        CH_U: begin
                            o_state           = '{mode: MODE_HEX, hex_cnt: 2'd0, code: 12'd0};
                            o_step.has_result = 1'b0;
                            o_step.item.byte_count = 2'd0;
                        end
                        default: begin
                            o_state           = '{mode: MODE_ERROR, hex_cnt: 2'd0, code: 12'd0};
                            o_step.item.kind  = KIND_BAD_ESC;
                            o_step.item.byte_count = 2'd0;
                        end
                    endcase
                end
                MODE_HEX: begin
                    if (!hex.ok) begin
                        o_state           = '{mode: MODE_ERROR, hex_cnt: 2'd0, code: 12'd0};
                        o_step.has_result = 1'b1;
                        o_step.item.kind  = KIND_BAD_HEX;
                    end else if (i_state.hex_cnt == HEX_LAST) begin
                        o_state           = '{mode: MODE_STRING, hex_cnt: 2'd0, code: 12'd0};
                        o_step.has_result = 1'b1;
                        o_step.item       = utf8(cp);
                    end else begin
                        o_state.code    = {i_state.code[7:0], hex.val};
                        o_state.hex_cnt = i_state.hex_cnt + 2'd1;
                    end
                end
                default: begin
                end
            endcase
        end
    end

endmodule

`default_nettype wire

/* rtl/core/json_string_unescape_unit.sv */
// JSON string unescape unit: top level with state, output register and skid stage.
//
// Takes a JSON text one byte per item, ending with an end-of-text item, and
// unescapes the single string literal it must start with. Plain bytes come
// out as one-byte data results; the escapes \" \\ \/ \b \f \n \r \t give one
// byte each, and \uXXXX (hex in either case) gives one to three UTF-8 bytes in
// a single result. A closing quote gives a closed result; each error (no
// opening quote, unfinished escape, bad escape letter, bad hex digit, short
// \u escape, unterminated string) is reported once, and later bytes are
// dropped until end-of-text, which always returns the unit to its reset
// state. Many items give no result at all. Throughput is one item per clock:
// the parser state updates in the cycle the item is accepted, and the result
// goes into an output register backed by a one-entry skid register, so input
// is stalled only while that skid register is full. When the output is not
// stalled, a result reaches the output in the cycle after its item is accepted.
`default_nettype none

module json_string_unescape_unit (
    input  wire                logic i_clk,
    input  wire                logic i_rst_n,
    input  wire                logic i_in_valid,
    output                     logic o_in_stall,
    input  jsu_pkg::t_in_item        i_in_item,
    output                     logic o_out_valid,
    input  wire                logic i_out_stall,
    output jsu_pkg::t_out_item       o_out_item
);
    import jsu_pkg::*;

    `include "json_string_unescape_unit_assert.svh"

    t_state    r_state;
    t_state    n_state;
    t_step     step;
    logic      r_out_valid;
    logic      n_out_valid;
    t_out_item r_out_item;
    t_out_item n_out_item;
    logic      r_skid_valid;
    logic      n_skid_valid;
    t_out_item r_skid_item;
    t_out_item n_skid_item;
    logic      in_acc;
    logic      out_take;

    // Stall input only while the skid register holds a result.
    assign o_in_stall = r_skid_valid;
    assign in_acc     = i_in_valid && !r_skid_valid;
    assign out_take   = r_out_valid && !i_out_stall;

    jsu_step u_step (
        .i_item  (i_in_item),
        .i_state (r_state),
        .o_state (n_state),
        .o_step  (step)
    );

    // Route the new result: to the output register when it frees up,
    // otherwise park it in the skid register.
    always_comb begin
        n_out_valid  = r_out_valid;
        n_out_item   = r_out_item;
        n_skid_valid = r_skid_valid;
        n_skid_item  = r_skid_item;
        if (!r_out_valid || out_take) begin
            if (r_skid_valid) begin
                n_out_valid  = 1'b1;
                n_out_item   = r_skid_item;
                n_skid_valid = 1'b0;
            end else begin
                n_out_valid = in_acc && step.has_result;
                n_out_item  = step.item;
            end
        end else if (in_acc && step.has_result) begin
            n_skid_valid = 1'b1;
            n_skid_item  = step.item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_RESET;
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (in_acc) begin
                r_state <= n_state;
            end
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    // Payload: no reset needed.
    always_ff @(posedge i_clk) begin
        r_out_item  <= n_out_item;
        r_skid_item <= n_skid_item;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    `JSU_ASSERT_SAME(a_skid_behind_out, r_skid_valid, r_out_valid, "skid full with output empty")
    `JSU_ASSERT_NEXT(a_end_resets, in_acc && i_in_item.action == ACT_END, r_state == ST_RESET, "end-of-text did not reset state")
    `JSU_ASSERT_SAME(a_hex_cnt_mode, r_state.hex_cnt != 2'd0, r_state.mode == MODE_HEX, "hex count outside hex mode")
    `JSU_ASSERT_SAME(a_count_kind, o_out_valid && o_out_item.kind != KIND_DATA, o_out_item.byte_count == 2'd0, "non-data result with bytes")

endmodule

`default_nettype wire

/* bench/tb_json_string_unescape_unit.sv */
// Self-checking testbench for the JSON string unescape unit.
`timescale 1ns / 100ps

import jsu_pkg::*;

// Tracks the unescaper's parse state and holds the results it must produce.
class unescape_scoreboard;
    t_mode       parse_mode  = MODE_AWAIT;
    logic [1:0]  digit_count = 2'd0;
    logic [15:0] code_point  = 16'd0;
    t_out_item   expected_results[$];
    int          items_taken   = 0;
    int          results_taken = 0;
    int          errors        = 0;
    int          kind_seen[8]  = '{default: 0};
    int          size_seen[4]  = '{default: 0};
    bit          field_bad;

    // Advance the parse state by one accepted item and queue any result.
    function void take_item(t_in_item it);
        t_out_item  res;
        logic       emit;
        logic [7:0] c;
        logic [4:0] nib;
        res = '0;
        emit = 1'b0;
        c = it.text_byte;
        nib = 5'h10;
        items_taken++;
        if (it.action == ACT_END) begin
            emit = 1'b1;
            case (parse_mode)
                MODE_AWAIT:  res.kind = KIND_NO_OPEN;
                MODE_STRING: res.kind = KIND_UNTERM;
                MODE_ESCAPE: res.kind = KIND_UNFINISHED;
                MODE_HEX:    res.kind = KIND_SHORT_U;
                default:     emit = 1'b0;
            endcase
            parse_mode = MODE_AWAIT;
            digit_count = 2'd0;
            code_point = 16'd0;
        end else begin
            case (parse_mode)
                MODE_AWAIT: begin
                    if (c == CH_QUOTE) begin
                        parse_mode = MODE_STRING;
                    end else begin
                        emit = 1'b1;
                        res.kind = KIND_NO_OPEN;
                        parse_mode = MODE_ERROR;
                    end
                end
                MODE_STRING: begin
                    emit = (c != CH_BSLASH);
                    if (c == CH_QUOTE) begin
                        res.kind = KIND_CLOSED;
                        parse_mode = MODE_CLOSED;
                    end else if (c == CH_BSLASH) begin
                        parse_mode = MODE_ESCAPE;
                    end else begin
                        res.kind = KIND_DATA;
                        res.byte_count = 2'd1;
                        res.first_byte = c;
                    end
                end
                MODE_ESCAPE: begin
                    emit = 1'b1;
                    parse_mode = MODE_STRING;
                    res.kind = KIND_DATA;
                    res.byte_count = 2'd1;
                    case (c)
                        CH_QUOTE, CH_BSLASH, CH_SLASH: res.first_byte = c;
                        CH_B: res.first_byte = CTL_BS;
                        CH_F: res.first_byte = CTL_FF;
                        CH_N: res.first_byte = CTL_LF;
                        CH_R: res.first_byte = CTL_CR;
                        CH_T: res.first_byte = CTL_TAB;
                        CH_U: begin
                            emit = 1'b0;
                            parse_mode = MODE_HEX;
                            digit_count = 2'd0;
                            code_point = 16'd0;
                        end
                        default: begin
                            res = '0;
                            res.kind = KIND_BAD_ESC;
                            parse_mode = MODE_ERROR;
                        end
                    endcase
                end
                MODE_HEX: begin
                    if (c >= 8'h30 && c <= 8'h39)
                        nib = {1'b0, c[3:0]};
                    else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66))
                        nib = {1'b0, c[3:0] + 4'd9};
                    if (nib[4]) begin
                        emit = 1'b1;
                        res.kind = KIND_BAD_HEX;
                        parse_mode = MODE_ERROR;
                    end else begin
                        code_point = {code_point[11:0], nib[3:0]};
                        if (digit_count == HEX_LAST) begin
                            emit = 1'b1;
                            res.kind = KIND_DATA;
                            if (code_point <= 16'h007f) begin
                                res.byte_count = 2'd1;
                                res.first_byte = code_point[7:0];
                            end else if (code_point <= 16'h07ff) begin
                                res.byte_count = 2'd2;
                                res.first_byte = {3'b110, code_point[10:6]};
                                res.second_byte = {2'b10, code_point[5:0]};
                            end else begin
                                res.byte_count = 2'd3;
                                res.first_byte = {4'b1110, code_point[15:12]};
                                res.second_byte = {2'b10, code_point[11:6]};
                                res.third_byte = {2'b10, code_point[5:0]};
                            end
                            parse_mode = MODE_STRING;
                            digit_count = 2'd0;
                            code_point = 16'd0;
                        end else begin
                            digit_count = digit_count + 2'd1;
                        end
                    end
                end
                default: ;
            endcase
        end
        if (emit)
            expected_results.insert(expected_results.size(), res);
    endfunction

    function void check_field(string field, logic [7:0] want, logic [7:0] got);
        if (got !== want) begin
            $error("%s mismatch: expected 0x%02h, got 0x%02h", field, want, got);
            field_bad = 1'b1;
        end
    endfunction

    // Compare one delivered result against the oldest outstanding one.
    function void check_result(t_out_item got);
        t_out_item want;
        if (expected_results.size() == 0) begin
            $error("kind mismatch: expected no result, got kind %0d", got.kind);
            errors++;
            return;
        end
        want = expected_results.pop_front();
        field_bad = 1'b0;
        check_field("kind", 8'(want.kind), 8'(got.kind));
        check_field("byte_count", 8'(want.byte_count), 8'(got.byte_count));
        check_field("first_byte", want.first_byte, got.first_byte);
        check_field("second_byte", want.second_byte, got.second_byte);
        check_field("third_byte", want.third_byte, got.third_byte);
        if (field_bad)
            errors++;
        results_taken++;
        kind_seen[want.kind]++;
        if (want.kind == KIND_DATA)
            size_seen[want.byte_count]++;
    endfunction
endclass

module tb_json_string_unescape_unit;

    localparam int TOTAL_ITEMS = 1650;  // stop the stimulus near this many live items
    localparam int CALM_ITEMS  = 250;   // final stretch with no idling on either side
    localparam int STUCK_LIMIT = 1000;  // cycles without any handshake before giving up

    logic      clk;
    logic      rst_n;
    logic      in_valid;
    logic      in_stall;
    t_in_item  in_item;
    logic      out_valid;
    logic      out_stall;
    t_out_item out_item;

    unescape_scoreboard sb = new;
    bit calm = 1'b0;
    int items_sent = 0;
    int stuck_cycles = 0;

    // Letters that form a legal one-byte escape after a backslash.
    logic [7:0] escape_letters[8] = '{CH_QUOTE, CH_BSLASH, CH_SLASH, CH_B,
                                      CH_F, CH_N, CH_R, CH_T};

    json_string_unescape_unit dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_item  (out_item)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Observe both handshakes on the clock edge; values read here are the
    // ones that were stable before the edge, so ordering within the step
    // does not matter. Note inputs before checking outputs so that an
    // expectation raised this edge is already queued.
    always @(posedge clk) begin
        if (rst_n) begin
            if (in_valid && !in_stall)
                sb.take_item(in_item);
            if (out_valid && !out_stall)
                sb.check_result(out_item);
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                stuck_cycles <= 0;
            else
                stuck_cycles <= stuck_cycles + 1;
            if (stuck_cycles == STUCK_LIMIT) begin
                $display("watchdog: no handshake for %0d cycles", STUCK_LIMIT);
                $display("json_string_unescape_unit verification failed");
                $finish;
            end
        end
    end

    // Output back-pressure: random stall bursts, quiet during the calm stretch.
    initial begin
        out_stall <= 1'b0;
        @(posedge clk);
        while (!rst_n) @(posedge clk);
        forever begin
            if (!calm && $urandom_range(0, 2) == 0) begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 5)) @(posedge clk);
                out_stall <= 1'b0;
            end
            // Hold the stall low for a while; now and then for a long stretch.
            if ($urandom_range(0, 9) == 0)
                repeat ($urandom_range(20, 60)) @(posedge clk);
            else
                repeat ($urandom_range(1, 8)) @(posedge clk);
        end
    end

    // Offer one item, maybe after an idle burst, and hold it until accepted.
    // Items that the unit only drops are flagged so they do not count.
    task automatic push_item(input logic act, input logic [7:0] b, input bit counts);
        if (!calm && $urandom_range(0, 4) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item <= '{action: act, text_byte: b};
        do @(posedge clk); while (in_stall);
        if (counts)
            items_sent++;
    endtask

    function automatic logic [7:0] hex_char(input logic [3:0] v);
        if (v < 4'd10)
            return 8'h30 + 8'(v);
        return ($urandom_range(0, 1) ? 8'h41 : 8'h61) + 8'(v - 4'd10);
    endfunction

    // Spread code points over the 1-, 2- and 3-byte UTF-8 ranges and their edges.
    function automatic logic [15:0] pick_code_point();
        logic [15:0] corner_points[6] = '{16'h0000, 16'h007f, 16'h0080,
                                          16'h07ff, 16'h0800, 16'hffff};
        case ($urandom_range(0, 3))
            0: return 16'($urandom_range(0, 16'h007f));
            1: return 16'($urandom_range(16'h0080, 16'h07ff));
            2: return 16'($urandom_range(16'h0800, 16'hffff));
            default: return corner_points[$urandom_range(0, 5)];
        endcase
    endfunction

    // Send a backslash-u escape carrying the top 'digits' hex digits of cp.
    task automatic send_unicode(input int digits, input logic [15:0] cp);
        push_item(ACT_BYTE, CH_BSLASH, 1'b1);
        push_item(ACT_BYTE, CH_U, 1'b1);
        for (int i = 0; i < digits; i++)
            push_item(ACT_BYTE, hex_char(cp[15 - 4 * i -: 4]), 1'b1);
    endtask

    // String body: plain bytes, simple escapes and unicode escapes.
    task automatic send_body(input int count);
        int         pick;
        logic [7:0] b;
        for (int k = 0; k < count; k++) begin
            pick = $urandom_range(0, 9);
            if (pick < 6) begin
                do b = 8'($urandom_range(0, 255)); while (b == CH_QUOTE || b == CH_BSLASH);
                push_item(ACT_BYTE, b, 1'b1);
            end else if (pick < 8) begin
                push_item(ACT_BYTE, CH_BSLASH, 1'b1);
                push_item(ACT_BYTE, escape_letters[$urandom_range(0, 7)], 1'b1);
            end else begin
                send_unicode(4, pick_code_point());
            end
        end
    endtask

    // One text ending in end-of-text: mostly a well-formed string, otherwise
    // one of the broken shapes (no quote, cut short, bad escape, bad hex, noise).
    task automatic send_random_text();
        int         flaw;
        int         len;
        logic [7:0] b;
        logic       hit;
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(11, 40) : $urandom_range(0, 10);
        flaw = ($urandom_range(0, 99) < 75) ? 0 : $urandom_range(1, 7);
        if (flaw != 1 && flaw != 7) begin
            push_item(ACT_BYTE, CH_QUOTE, 1'b1);
            send_body(len);
        end
        case (flaw)
            0: push_item(ACT_BYTE, CH_QUOTE, 1'b1);
            1: begin
                do b = 8'($urandom_range(0, 255)); while (b == CH_QUOTE);
                push_item(ACT_BYTE, b, 1'b1);
            end
            2: ;  // unterminated
            3: push_item(ACT_BYTE, CH_BSLASH, 1'b1);
            4: begin
                do begin
                    b = 8'($urandom_range(0, 255));
                    hit = (b == CH_U);
                    foreach (escape_letters[i])
                        if (escape_letters[i] == b)
                            hit = 1'b1;
                end while (hit);
                push_item(ACT_BYTE, CH_BSLASH, 1'b1);
                push_item(ACT_BYTE, b, 1'b1);
            end
            5: begin
                do b = 8'($urandom_range(0, 255));
                while ((b >= 8'h30 && b <= 8'h39) || (b >= 8'h41 && b <= 8'h46) ||
                       (b >= 8'h61 && b <= 8'h66));
                send_unicode($urandom_range(0, 3), pick_code_point());
                push_item(ACT_BYTE, b, 1'b1);
            end
            6: send_unicode($urandom_range(0, 3), pick_code_point());
            default: begin
                repeat ($urandom_range(1, 6)) begin
                    case ($urandom_range(0, 3))
                        0: b = CH_QUOTE;
                        1: b = CH_BSLASH;
                        2: b = CH_U;
                        default: b = 8'($urandom_range(0, 255));
                    endcase
                    push_item(ACT_BYTE, b, 1'b1);
                end
            end
        endcase
        // Trailing bytes after a close or an error are only dropped.
        if ((flaw == 0 || flaw == 1 || flaw == 4 || flaw == 5) && $urandom_range(0, 2) == 0)
            repeat ($urandom_range(1, 3))
                push_item(ACT_BYTE, 8'($urandom_range(0, 255)), 1'b0);
        push_item(ACT_END, 8'($urandom_range(0, 255)), 1'b1);
    endtask

    initial begin
        rst_n <= 1'b0;
        in_valid <= 1'b0;
        in_item <= '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // Empty text: end-of-text while still waiting for the opening quote.
        push_item(ACT_END, 8'h00, 1'b1);
        // Opening quote then end: unterminated string.
        push_item(ACT_BYTE, CH_QUOTE, 1'b1);
        push_item(ACT_END, 8'hff, 1'b1);
        // End right after a backslash: unfinished escape.
        push_item(ACT_BYTE, CH_QUOTE, 1'b1);
        push_item(ACT_BYTE, CH_BSLASH, 1'b1);
        push_item(ACT_END, 8'h00, 1'b1);
        // Unknown escape letter, then end after the error gives nothing.
        push_item(ACT_BYTE, CH_QUOTE, 1'b1);
        push_item(ACT_BYTE, CH_BSLASH, 1'b1);
        push_item(ACT_BYTE, 8'h71, 1'b1);
        push_item(ACT_END, 8'h00, 1'b1);
        // Non-hex byte inside a unicode escape is flagged on arrival.
        push_item(ACT_BYTE, CH_QUOTE, 1'b1);
        push_item(ACT_BYTE, CH_BSLASH, 1'b1);
        push_item(ACT_BYTE, CH_U, 1'b1);
        push_item(ACT_BYTE, 8'h67, 1'b1);
        push_item(ACT_END, 8'h00, 1'b1);
        // End inside the hex digits: short unicode escape.
        push_item(ACT_BYTE, CH_QUOTE, 1'b1);
        push_item(ACT_BYTE, CH_BSLASH, 1'b1);
        push_item(ACT_BYTE, CH_U, 1'b1);
        push_item(ACT_BYTE, 8'h37, 1'b1);
        push_item(ACT_END, 8'h00, 1'b1);
        // Top byte value as data, the zero code point, a close, a dropped byte
        // after the close, and a silent end.
        push_item(ACT_BYTE, CH_QUOTE, 1'b1);
        push_item(ACT_BYTE, 8'hff, 1'b1);
        send_unicode(4, 16'h0000);
        push_item(ACT_BYTE, CH_QUOTE, 1'b1);
        push_item(ACT_BYTE, 8'h00, 1'b0);
        push_item(ACT_END, 8'h00, 1'b1);
        // Missing opening quote, then end after the error.
        push_item(ACT_BYTE, 8'hff, 1'b1);
        push_item(ACT_END, 8'hff, 1'b1);

        // Random texts; drop all idling for the last stretch.
        while (items_sent < TOTAL_ITEMS) begin
            if (items_sent >= TOTAL_ITEMS - CALM_ITEMS)
                calm = 1'b1;
            send_random_text();
        end
        in_valid <= 1'b0;

        // Drain, then give a stray result a few cycles to show up.
        while (sb.expected_results.size() != 0) @(posedge clk);
        repeat (6) @(posedge clk);

        $display("Ran %0d items into %0d results: %0d data (1/2/3 bytes %0d/%0d/%0d),",
                 sb.items_taken, sb.results_taken, sb.kind_seen[KIND_DATA], sb.size_seen[1],
                 sb.size_seen[2], sb.size_seen[3]);
        $display("%0d closed; errors: no-open %0d, unfinished %0d, bad escape %0d,",
                 sb.kind_seen[KIND_CLOSED], sb.kind_seen[KIND_NO_OPEN],
                 sb.kind_seen[KIND_UNFINISHED], sb.kind_seen[KIND_BAD_ESC]);
        $display("bad hex %0d, short u %0d, unterminated %0d",
                 sb.kind_seen[KIND_BAD_HEX], sb.kind_seen[KIND_SHORT_U],
                 sb.kind_seen[KIND_UNTERM]);
        if (sb.errors == 0 && sb.expected_results.size() == 0)
            $display("json_string_unescape_unit verification clean");
        else
            $display("json_string_unescape_unit verification failed");
        $finish;
    end

endmodule

/* filelist.f */
+incdir+rtl/core
rtl/core/jsu_pkg.sv
rtl/core/jsu_step.sv
rtl/core/json_string_unescape_unit.sv
bench/tb_json_string_unescape_unit.sv
